/* hw/rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the Sobel edge magnitude block
// Pixel and window types, lane status and configuration defaults.
// ----------------------------------------------------------------------------
package sem_pkg;

   // pixel component width and number of color lanes
   localparam int PIX_W     = 8;
   localparam int NUM_LANES = 3;
   localparam int RGB_W     = PIX_W * NUM_LANES;

   // default sizing of the line memories and row counters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // configuration registers
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // magnitude limits
   localparam logic [20:0] SAT_LIMIT = 21'd65280;
   localparam logic [7:0]  MAG_MAX   = 8'd255;

   // 3x3 neighborhood of one channel, index row*3 + column
   typedef logic [8:0][PIX_W-1:0] win_type;

   // status a lane reports to the merge stage
   typedef struct packed {
      logic             busy;
      logic [PIX_W-1:0] mag;
   } lane_out_type;

endpackage

/* hw/rtl/sem_ram.sv */
// ----------------------------------------------------------------------------
// sem_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sem_lane.sv */
// ----------------------------------------------------------------------------
// sem_lane: Sobel gradient and rounded magnitude for one color channel
// Gradients, squares, then a bit-per-cycle integer square root (8 steps).
// ----------------------------------------------------------------------------
module sem_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sem_pkg::win_type      taps,
   output sem_pkg::lane_out_type status
);
   import sem_pkg::*;

   localparam logic [3:0] STEP_SQUARE = 4'd0;
   localparam logic [3:0] STEP_SUM    = 4'd1;
   localparam logic [3:0] STEP_LAST   = 4'd9;

   logic               busy_ff;
   logic [3:0]         step_ff;
   logic signed [10:0] gx_ff, gy_ff;
   logic [19:0]        sqx_ff, sqy_ff;
   logic               sat_ff;
   logic [15:0]        op_ff, res_ff, one_ff;

   logic [9:0]         right_sum, left_sum, bot_sum, top_sum;
   logic signed [21:0] gx_sq, gy_sq;
   logic [20:0]        sq_sum;
   logic [16:0]        trial;

   // kernel sums
   always_comb begin
      right_sum = 10'(taps[2]) + {1'b0, taps[5], 1'b0} + 10'(taps[8]);
      left_sum  = 10'(taps[0]) + {1'b0, taps[3], 1'b0} + 10'(taps[6]);
      bot_sum   = 10'(taps[6]) + {1'b0, taps[7], 1'b0} + 10'(taps[8]);
      top_sum   = 10'(taps[0]) + {1'b0, taps[1], 1'b0} + 10'(taps[2]);
      gx_sq     = gx_ff * gx_ff;
      gy_sq     = gy_ff * gy_ff;
      sq_sum    = 21'(sqx_ff) + 21'(sqy_ff);
      trial     = 17'(res_ff) + 17'(one_ff);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_SQUARE;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= STEP_SQUARE;
      end else if (busy_ff) begin
         step_ff <= step_ff + 4'd1;
         if (step_ff == STEP_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         gx_ff <= $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
         gy_ff <= $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
      end else if (busy_ff) begin
         case (step_ff)
            STEP_SQUARE: begin
               sqx_ff <= 20'(gx_sq);
               sqy_ff <= 20'(gy_sq);
            end
            STEP_SUM: begin
               sat_ff <= (sq_sum > SAT_LIMIT);
               op_ff  <= sq_sum[15:0];
               res_ff <= '0;
               one_ff <= 16'h4000;
            end
            default: begin
               // one root bit per cycle
               if ({1'b0, op_ff} >= trial) begin
                  op_ff  <= op_ff - trial[15:0];
                  res_ff <= (res_ff >> 1) + one_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               one_ff <= one_ff >> 2;
            end
         endcase
      end
   end

   // round to nearest: remainder above n means s > n*n + n
   assign status.busy = busy_ff;
   assign status.mag  = sat_ff ? MAG_MAX : 8'(res_ff + 16'(op_ff > res_ff));

endmodule

/* hw/rtl/sobel_edge_magnitude_rgb.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel edge magnitude on RGB pixels
// Two line memories feed a 3x3 window; three channel lanes compute the
// rounded gradient magnitude and a merge stage packs the result.
// ----------------------------------------------------------------------------
// Order: outputs trail inputs by frame_width+1 items. A new item is taken only
//   once the last one is done; an item that yields a result also waits for the
//   8-step square root in the lanes and for a free output register.
// Reset: synchronous, active high; width 640, height 480, frame restarted.
//   Line memories are not cleared; the window masks data of earlier frames.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // in_blue, in_green, in_red
   input  logic                           req_tuser,   // action
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // out_blue, out_green, out_red
   output logic                           rsp_tlast,   // frame_end
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0] csr_data
);
   import sem_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_GRAD = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [FW_W-1:0]    width_ff;
   logic [FH_W-1:0]    height_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   qcol_ff;
   logic [HGT_W-1:0]   qrow_ff;
   logic [COL_W-1:0]   item_col_ff;
   logic [RGB_W-1:0]   val_ff;
   logic               has_out_ff;
   logic [2:0][2:0][RGB_W-1:0] win_ff;
   logic               last_ff;
   logic               rsp_valid_ff;
   logic [RGB_W-1:0]   rsp_data_ff;
   logic               rsp_last_ff;

   logic [WID_W-1:0]   eff_w;
   logic [HGT_W-1:0]   eff_h;
   logic               accept, restart, col_wrap, qcol_end, q_last;
   logic               out_free, lanes_busy;
   logic [RGB_W-1:0]   lb1_rd, lb2_rd;
   win_type            taps [NUM_LANES];
   lane_out_type       lane_st [NUM_LANES];

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HGT_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HGT_W'(MAX_HEIGHT);
      end else begin
         eff_h = HGT_W'(height_ff);
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign restart    = csr_valid && ((csr_index == REG_FRAME_WIDTH) ||
                                     (csr_index == REG_FRAME_HEIGHT));
   assign col_wrap   = (WID_W'(col_ff) == WID_W'(eff_w - WID_W'(1)));
   assign qcol_end   = (WID_W'(qcol_ff) == WID_W'(eff_w - WID_W'(1)));
   assign q_last     = qcol_end && (qrow_ff == HGT_W'(eff_h - HGT_W'(1)));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_data[FW_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = has_out_ff ? ST_GRAD : ST_IDLE;
         ST_GRAD: state_in = ST_WAIT;
         ST_WAIT: if (!lanes_busy && out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // input position and output position counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         qcol_ff <= '0;
         qrow_ff <= '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end else if (state_ff == ST_GRAD) begin
         if (q_last) begin
            col_ff  <= '0;
            row_ff  <= '0;
            qcol_ff <= '0;
            qrow_ff <= '0;
         end else if (qcol_end) begin
            qcol_ff <= '0;
            qrow_ff <= qrow_ff + HGT_W'(1);
         end else begin
            qcol_ff <= qcol_ff + COL_W'(1);
         end
      end
   end

   // capture of the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         item_col_ff <= col_ff;
         has_out_ff  <= !((row_ff == '0) || ((row_ff == ROW_W'(1)) && (col_ff == '0)));
         if (!req_tuser && (32'(row_ff) < 32'(eff_h))) begin
            val_ff <= req_tdata;
         end else begin
            val_ff <= '0;
         end
      end
   end

   // line memories: row above and two rows above
   sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_line1 (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (item_col_ff),
      .wr_data (val_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (lb1_rd)
   );

   sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_line2 (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (item_col_ff),
      .wr_data (lb1_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (lb2_rd)
   );

   // window shift: column 2 newest, row 0 top
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= {val_ff, lb1_rd, lb2_rd};
      end
   end

   // frame-edge masking per lane
   always_comb begin
      for (int ch = 0; ch < NUM_LANES; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if ((c == 0 && qcol_ff == '0) || (c == 2 && qcol_end) ||
                   (r == 0 && qrow_ff == '0)) begin
                  taps[ch][r*3+c] = '0;
               end else begin
                  taps[ch][r*3+c] = win_ff[c][r][ch*PIX_W +: PIX_W];
               end
            end
         end
      end
   end

   // channel lanes: blue, green, red
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      sem_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (state_ff == ST_GRAD),
         .taps   (taps[g]),
         .status (lane_st[g])
      );
   end

   always_comb begin
      lanes_busy = 1'b0;
      for (int ch = 0; ch < NUM_LANES; ch++) begin
         lanes_busy = lanes_busy | lane_st[ch].busy;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_GRAD) begin
         last_ff <= q_last;
      end
   end

   // merge stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_WAIT && !lanes_busy && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WAIT && !lanes_busy && out_free) begin
         for (int ch = 0; ch < NUM_LANES; ch++) begin
            rsp_data_ff[ch*PIX_W +: PIX_W] <= lane_st[ch].mag;
         end
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/sem_checker.sv */
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the Sobel edge magnitude block
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module sem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // one item in flight: no transaction right after another
   a_req_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on back-to-back cycles");

   // no new result can show up straight after an input transaction
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);
